FILE: design/rdr_pkg.sv
// shared types and constants of the reliable datagram receiver
package rdr_pkg;

	// port widths
	localparam int unsigned S_TDATA_W  = 48;
	localparam int unsigned S_TUSER_W  = 3;
	localparam int unsigned M_TDATA_W  = 272;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;

	// payload limit and register reset values
	localparam logic [10:0] MAX_PAYLOAD   = 11'd1024;
	localparam logic [7:0]  WINDOW_RESET  = 8'd10;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	// decoupling queue
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// statistics counter slots
	localparam int unsigned NUM_STATS = 7;
	localparam int unsigned ST_TBYTES = 0;
	localparam int unsigned ST_UBYTES = 1;
	localparam int unsigned ST_TPACKS = 2;
	localparam int unsigned ST_UPACKS = 3;
	localparam int unsigned ST_SYNS   = 4;
	localparam int unsigned ST_FINS   = 5;
	localparam int unsigned ST_ACKS   = 6;

	typedef enum logic [1:0] {
		PKT_SYN   = 2'd0,
		PKT_DAT   = 2'd1,
		PKT_FIN   = 2'd2,
		PKT_OTHER = 2'd3
	} pkt_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW  = 1'b0,
		CFG_TIMEOUT = 1'b1
	} cfg_reg_t;

	// classified input beat, payload length already clamped
	typedef struct packed {
		logic        is_tick;
		pkt_type_t   ptype;
		logic [31:0] seq;
		logic [10:0] dlen;
	} item_t;

	// result beat; last member sits in the lowest bits
	typedef struct packed {
		logic [31:0] ack_count;
		logic [31:0] fins_received;
		logic [31:0] syns_received;
		logic [31:0] unique_packets;
		logic [31:0] total_packets;
		logic [31:0] unique_bytes;
		logic [31:0] total_bytes;
		logic        closed;
		logic        store_payload;
		logic [7:0]  window_advertised;
		logic [31:0] ack_number;
		logic        send_ack;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);

endpackage

FILE: design/rdr_front.sv
// front end: unpacks and classifies incoming beats for the queue
module rdr_front (
	input  logic                           s_tvalid,
	input  logic [rdr_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [rdr_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                           item_valid,
	output rdr_pkg::item_t                 item
);
	import rdr_pkg::*;

	logic [10:0] raw_len;

	// field extraction
	assign raw_len = s_tdata[42:32];
	assign item_valid = s_tvalid;

	// classify and clamp oversized payloads
	always_comb begin
		item.is_tick = s_tuser[0];
		item.ptype   = pkt_type_t'(s_tuser[2:1]);
		item.seq     = s_tdata[31:0];
		item.dlen    = (raw_len > MAX_PAYLOAD) ? MAX_PAYLOAD : raw_len;
	end

endmodule

FILE: design/rdr_queue.sv
// short queue between the front end and the protocol engine
module rdr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  rdr_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop,
	output rdr_pkg::item_t pop_item
);
	import rdr_pkg::*;

	item_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                do_pop;

	// handshake decode
	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_item   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: design/rdr_back.sv
// protocol engine: connection state, statistics and the result register
module rdr_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  rdr_pkg::item_t                  item,
	output logic                            pop,
	input  logic                            cfg_we,
	input  logic [rdr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rdr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            res_valid,
	input  logic                            res_ready,
	output rdr_pkg::result_t                res
);
	import rdr_pkg::*;

	function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [10:0] amt);
		logic [32:0] sum;
		sum = {1'b0, v} + {22'd0, amt};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// configuration registers
	logic [7:0]  window_q;
	logic [15:0] tlimit_q;

	// connection state
	logic        connected_q;
	logic        fin_seen_q;
	logic        closed_q;
	logic [31:0] exp_seq_q;
	logic [7:0]  win_cnt_q;
	logic [15:0] idle_q;
	logic [31:0] stat_q [NUM_STATS];

	logic        connected_n;
	logic        fin_seen_n;
	logic        closed_n;
	logic [31:0] exp_seq_n;
	logic [7:0]  win_cnt_n;
	logic [15:0] idle_n;
	logic [31:0] stat_n [NUM_STATS];
	logic        ack;
	logic        store;
	logic [7:0]  cnt_inc;
	logic [15:0] idle_inc;
	logic [31:0] seq_inc;

	// result register
	logic        out_valid_q;
	result_t     res_q;

	assign pop       = item_valid && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;
	assign res       = res_q;

	assign cnt_inc  = (win_cnt_q == 8'hFF) ? win_cnt_q : win_cnt_q + 8'd1;
	assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
	assign seq_inc  = item.seq + 32'd1;

	// next state of one beat
	always_comb begin
		connected_n = connected_q;
		fin_seen_n  = fin_seen_q;
		closed_n    = closed_q;
		exp_seq_n   = exp_seq_q;
		win_cnt_n   = win_cnt_q;
		idle_n      = idle_q;
		ack         = 1'b0;
		store       = 1'b0;
		for (int i = 0; i < NUM_STATS; i++) begin
			stat_n[i] = stat_q[i];
		end
		if (!closed_q) begin
			if (item.is_tick) begin
				if (connected_q) begin
					ack       = !fin_seen_q;
					win_cnt_n = '0;
					idle_n    = idle_inc;
					if (idle_inc >= tlimit_q) begin
						closed_n = 1'b1;
					end
				end
			end else begin
				idle_n = '0;
				unique case (item.ptype)
					PKT_SYN: begin
						exp_seq_n        = seq_inc;
						ack              = 1'b1;
						connected_n      = 1'b1;
						stat_n[ST_SYNS]  = sat_add(stat_q[ST_SYNS], 11'd1);
					end
					PKT_DAT: begin
						stat_n[ST_TPACKS] = sat_add(stat_q[ST_TPACKS], 11'd1);
						stat_n[ST_TBYTES] = sat_add(stat_q[ST_TBYTES], item.dlen);
						if (item.seq == exp_seq_q) begin
							exp_seq_n         = seq_inc;
							store             = 1'b1;
							stat_n[ST_UPACKS] = sat_add(stat_q[ST_UPACKS], 11'd1);
							stat_n[ST_UBYTES] = sat_add(stat_q[ST_UBYTES], item.dlen);
							if (cnt_inc >= window_q) begin
								ack       = 1'b1;
								win_cnt_n = '0;
							end else begin
								win_cnt_n = cnt_inc;
							end
						end
					end
					PKT_FIN: begin
						fin_seen_n      = 1'b1;
						exp_seq_n       = seq_inc;
						ack             = 1'b1;
						stat_n[ST_FINS] = sat_add(stat_q[ST_FINS], 11'd1);
					end
					PKT_OTHER: begin
					end
					default: begin
					end
				endcase
			end
			if (ack) begin
				stat_n[ST_ACKS] = sat_add(stat_q[ST_ACKS], 11'd1);
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			tlimit_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_WINDOW:  window_q <= cfg_data[7:0];
				CFG_TIMEOUT: tlimit_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// state update on each popped beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			connected_q <= 1'b0;
			fin_seen_q  <= 1'b0;
			closed_q    <= 1'b0;
			exp_seq_q   <= '0;
			win_cnt_q   <= '0;
			idle_q      <= '0;
			for (int i = 0; i < NUM_STATS; i++) begin
				stat_q[i] <= '0;
			end
		end else if (pop) begin
			connected_q <= connected_n;
			fin_seen_q  <= fin_seen_n;
			closed_q    <= closed_n;
			exp_seq_q   <= exp_seq_n;
			win_cnt_q   <= win_cnt_n;
			idle_q      <= idle_n;
			for (int i = 0; i < NUM_STATS; i++) begin
				stat_q[i] <= stat_n[i];
			end
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.send_ack          <= ack;
			res_q.ack_number        <= exp_seq_n;
			res_q.window_advertised <= window_q;
			res_q.store_payload     <= store;
			res_q.closed            <= closed_n;
			res_q.total_bytes       <= stat_n[ST_TBYTES];
			res_q.unique_bytes      <= stat_n[ST_UBYTES];
			res_q.total_packets     <= stat_n[ST_TPACKS];
			res_q.unique_packets    <= stat_n[ST_UPACKS];
			res_q.syns_received     <= stat_n[ST_SYNS];
			res_q.fins_received     <= stat_n[ST_FINS];
			res_q.ack_count         <= stat_n[ST_ACKS];
		end
	end

	// closed never reopens
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("closed flag dropped");

	// a closed engine neither acknowledges nor stores
	a_closed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		pop && closed_q |=> !res_q.send_ack && !res_q.store_payload)
		else $error("activity after close");

	// a tick while connected clears the window count
	a_tick_clears_window: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !closed_q && connected_q && item.is_tick |=> win_cnt_q == '0)
		else $error("window count not cleared by tick");

	// a held result beat is not overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_ready |-> !pop)
		else $error("result beat overwritten while stalled");

endmodule

FILE: design/reliable_datagram_receiver.sv
// top level of the go-back-N datagram receiver with cumulative acks
//
// Slave channel: one beat per parsed packet header or per receive-timeout
// tick. tuser says what the beat is, tdata carries sequence and length.
// Master channel: exactly one result beat per input beat, in order, with
// the ack decision, ack number, advertised window, store strobe, closed
// flag and the seven saturating statistics counters.
// Config port: cfg_we writes window_packets (index 0) or timeout_limit
// (index 1) from cfg_data; write only while no beats are in flight.
// Path: a beat taken on the slave side is written into the queue, then
// popped into the result register that drives the master side.
// Throughput: one beat per cycle while the master side takes results;
// the four-entry queue lets the input side keep flowing for up to four
// beats while the master side stalls, after which s_tready drops until
// results are taken.
// Reset: all state cleared, window 10, timeout limit 100, queue empty.
module reliable_datagram_receiver (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// seq_num [31:0], payload_len [42:32], zero fill
	input  logic [rdr_pkg::S_TDATA_W-1:0]   s_tdata,
	// action [0], pkt_type [2:1]
	input  logic [rdr_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// send_ack [0], ack_number [32:1], window_advertised [40:33],
	// store_payload [41], closed [42], total_bytes [74:43],
	// unique_bytes [106:75], total_packets [138:107],
	// unique_packets [170:139], syns_received [202:171],
	// fins_received [234:203], ack_count [266:235], zero fill
	output logic [rdr_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                            cfg_we,
	input  logic [rdr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rdr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rdr_pkg::*;

	logic    front_valid;
	item_t   front_item;
	logic    q_valid;
	item_t   q_item;
	logic    q_pop;
	result_t res;

	// classify input beats
	rdr_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (front_valid),
		.item       (front_item)
	);

	// decoupling queue
	rdr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (s_tready),
		.push_item  (front_item),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_item   (q_item)
	);

	// protocol engine
	rdr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.pop        (q_pop),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	// pack the result beat
	assign m_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, res};

endmodule
